// File: rtl/bloom_filter_double_hash_core_defines.svh
// Assertion macros shared by the Bloom filter RTL.
`ifndef BLOOM_FILTER_DOUBLE_HASH_CORE_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASH_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFDH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define BFDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/bfdh_pkg.sv
// Package with constants and types of the double-hash Bloom filter.
`timescale 1ns / 1ps
package bfdh_pkg;
  localparam int FilterBits  = 65536;
  localparam int MaxHashes   = 16;
  localparam int CellBits    = 8;
  localparam int Cells       = FilterBits / CellBits;
  localparam int RowW        = $clog2(Cells);
  localparam int PosW        = $clog2(FilterBits);
  localparam int CountW      = 48;
  localparam int HashW       = 64;

  localparam logic [7:0] REG_HASH_COUNT  = 8'd0;
  localparam logic [7:0] REG_BITS_IN_USE = 8'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_t;
endpackage

// File: rtl/bloom_filter_double_hash_core.sv
// Each probe runs 64 restoring remainder steps, reads its store row and, for an insert,
// sets its bit; then the result is loaded into the output register (directly, with no
// probe, when zero probes are set). One item is in work at a time, and the bit-serial
// remainder sets the pace; a query that misses early finishes sooner. A finished result
// waits in the output register, and the next is not loaded until it is taken. Reset is
// synchronous: it restores the registers and counters, then zeroes all 8192 store rows, taking no request.
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_core_defines.svh"
module bloom_filter_double_hash_core
  import bfdh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // first_hash [63:0], second_hash [127:64]
  input  logic         s_tuser,   // operation (0 insert, 1 query)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // present [0], query_total [48:1], miss_total [96:49]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  state_t state, state_next;

  logic [4:0]        hash_count;
  logic [16:0]       bits_in_use;
  logic [RowW-1:0]   clear_row;
  logic              op;
  logic [HashW-1:0]  hb, sum, dividend;
  logic [PosW-1:0]   rem;
  logic [5:0]        bit_cnt;
  logic [3:0]        idx;
  logic [4:0]        k_eff;
  logic [16:0]       m_eff;
  logic              present;
  logic [CountW-1:0] query_cnt, miss_cnt;
  logic              out_valid;
  logic [103:0]      out_data;

  logic [CellBits-1:0] mem [Cells];
  logic [CellBits-1:0] rd_data;
  logic                mem_we;
  logic [RowW-1:0]     mem_addr;
  logic [CellBits-1:0] mem_wdata;

  logic [PosW:0]     step;
  logic              probe_bit;
  logic              last_probe;
  logic              miss_now;
  logic              in_acc;

  assign in_acc     = s_tvalid && s_tready;
  assign step       = {rem, dividend[HashW-1]};
  assign probe_bit  = rd_data[rem[2:0]];
  assign last_probe = ({1'b0, idx} + 5'd1) == k_eff;
  assign miss_now   = op && !probe_bit;

  always_comb begin
    if (hash_count > 5'(MaxHashes)) k_eff = 5'(MaxHashes);
    else k_eff = hash_count;
    if (bits_in_use == 17'd0) m_eff = 17'd1;
    else if (bits_in_use > 17'(FilterBits)) m_eff = 17'(FilterBits);
    else m_eff = bits_in_use;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_row == RowW'(Cells - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_acc) state_next = (k_eff == 5'd0) ? ST_DONE : ST_MOD;
      ST_MOD:    if (bit_cnt == 6'd63) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (last_probe || miss_now) state_next = ST_DONE;
                 else state_next = ST_MOD;
      ST_DONE:   if (!out_valid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = rem[PosW-1:3];
    mem_wdata = rd_data | (CellBits'(1) << rem[2:0]);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clear_row;
        mem_wdata = '0;
      end
      ST_IDLE:   s_tready = 1'b1;
      ST_UPDATE: mem_we = !op;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_row   <= '0;
      hash_count  <= 5'd4;
      bits_in_use <= 17'(FilterBits);
      query_cnt   <= '0;
      miss_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HASH_COUNT) hash_count <= cfg_data[4:0];
        else if (cfg_index == REG_BITS_IN_USE) bits_in_use <= cfg_data;
      end
      if (m_tvalid && m_tready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clear_row <= clear_row + RowW'(1);
        ST_IDLE: if (in_acc) begin
          op       <= s_tuser;
          hb       <= s_tdata[127:64];
          sum      <= s_tdata[63:0];
          dividend <= s_tdata[63:0];
          rem      <= '0;
          bit_cnt  <= '0;
          idx      <= '0;
          present  <= s_tuser;
          if (s_tuser) query_cnt <= query_cnt + CountW'(1);
        end
        ST_MOD: begin
          // One restoring step of the remainder per cycle.
          if (step >= m_eff) rem <= PosW'(step - m_eff);
          else rem <= step[PosW-1:0];
          dividend <= dividend << 1;
          bit_cnt  <= bit_cnt + 6'd1;
        end
        ST_UPDATE: begin
          if (miss_now) begin
            present  <= 1'b0;
            miss_cnt <= miss_cnt + CountW'(1);
          end
          // The running sum holds a + i*b; probe one takes b itself.
          sum      <= sum + hb;
          dividend <= (idx == 4'd0) ? hb : sum + hb;
          idx      <= idx + 4'd1;
          rem      <= '0;
          bit_cnt  <= '0;
        end
        ST_DONE: if (!out_valid || m_tready) begin
          out_valid <= 1'b1;
          out_data  <= {7'd0, miss_cnt, query_cnt, present};
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `BFDH_ASSERT_NOW(a_rem_range, clk, rst, state == ST_MOD, {1'b0, rem} < m_eff)
  `BFDH_ASSERT_NOW(a_idx_range, clk, rst, state == ST_MOD, {1'b0, idx} < k_eff)
  `BFDH_ASSERT_NOW(a_no_take_clear, clk, rst, state == ST_CLEAR, !s_tready)
  `BFDH_ASSERT_NEXT(a_query_count, clk, rst, in_acc && s_tuser,
                    query_cnt == $past(query_cnt) + CountW'(1))
endmodule

// File: sim/bloom_filter_double_hash_core_tb.sv
// Self-checking testbench for the double-hash Bloom filter core.
`timescale 1ns / 1ps
module bloom_filter_double_hash_core_tb;
  import bfdh_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
  localparam logic [7:0] REG_UNUSED = 8'd7;

  typedef struct packed {
    logic        present;
    logic [47:0] query_total;
    logic [47:0] miss_total;
  } answer_t;

  typedef struct {
    logic        op;
    logic [63:0] ha;
    logic [63:0] hb;
    logic        known;
    logic        present;
    logic [47:0] qtot;
    logic [47:0] mtot;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  bloom_filter_double_hash_core uut (.*);

  always #6 clk = ~clk;

  // Local copy of the filter state.
  bit          shadow_bits [FilterBits];
  logic [4:0]  probes_reg;
  logic [16:0] width_reg;
  logic [47:0] queries_seen;
  logic [47:0] misses_seen;

  answer_t awaited_answers[$];
  int      errors = 0;
  bit      hold_off = 1'b0;

  function automatic int bit_slot(logic [63:0] h);
    logic [63:0] m;
    m = width_reg;
    if (m == 0) m = 1;
    if (m > FilterBits) m = FilterBits;
    return int'(h % m);
  endfunction

  function automatic answer_t filter_lookup(logic op, logic [63:0] ha, logic [63:0] hb);
    answer_t     r;
    int          k;
    logic [63:0] h;
    k = (probes_reg > MaxHashes) ? MaxHashes : probes_reg;
    r.present = 1'b0;
    if (op == OP_QUERY) begin
      r.present = 1'b1;
      queries_seen = queries_seen + 1;
    end
    for (int i = 0; i < k; i++) begin
      h = (i == 0) ? ha : (i == 1) ? hb : ha + 64'(i) * hb;
      if (op == OP_INSERT) begin
        shadow_bits[bit_slot(h)] = 1'b1;
      end else if (!shadow_bits[bit_slot(h)]) begin
        r.present = 1'b0;
        misses_seen = misses_seen + 1;
        break;
      end
    end
    r.query_total = queries_seen;
    r.miss_total  = misses_seen;
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // Returns at the falling edge after acceptance with tvalid still high; the next
  // request either replaces the data right there or drops tvalid for its gap.
  task automatic send_request(logic op, logic [63:0] ha, logic [63:0] hb);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      idle_cycles(gap);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {hb, ha};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_answers.push_back(filter_lookup(op, ha, hb));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [16:0] val);
    s_tvalid <= 1'b0;
    // Let any item still in work drain first.
    while (awaited_answers.size() != 0) @(negedge clk);
    idle_cycles(1200);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HASH_COUNT) probes_reg = val[4:0];
    else if (idx == REG_BITS_IN_USE) width_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int key_pool);
    logic [63:0] pool_a [64];
    logic [63:0] pool_b [64];
    logic        op;
    int          j;
    for (int i = 0; i < 64; i++) begin
      pool_a[i] = {$urandom, $urandom};
      pool_b[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < n; i++) begin
      op = 1'($urandom_range(0, 1));
      j = $urandom_range(0, key_pool - 1);
      // Mostly reuse keys so queries often find their inserts.
      if ($urandom_range(0, 3) == 0) send_request(op, {$urandom, $urandom}, {$urandom, $urandom});
      else send_request(op, pool_a[j], pool_b[j]);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Checker.
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.present     = m_tdata[0];
      got.query_total = m_tdata[48:1];
      got.miss_total  = m_tdata[96:49];
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        if (got.present !== want.present)
          $display("%0t: present expected %0d actual %0d", $time, want.present, got.present);
        if (got.query_total !== want.query_total)
          $display("%0t: query_total expected %0d actual %0d", $time,
                   want.query_total, got.query_total);
        if (got.miss_total !== want.miss_total)
          $display("%0t: miss_total expected %0d actual %0d", $time,
                   want.miss_total, got.miss_total);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t    rows [$];
    answer_t a;
    probes_reg = 5'd4;
    width_reg = 17'd65536;
    queries_seen = '0;
    misses_seen = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: fresh filter answers absent, counters read off directly.
    rows.push_back('{OP_QUERY,  64'd0, 64'd0, 1'b1, 1'b0, 48'd1, 48'd1});
    rows.push_back('{OP_QUERY,  '1, '1, 1'b1, 1'b0, 48'd2, 48'd2});
    rows.push_back('{OP_INSERT, '1, '1, 1'b1, 1'b0, 48'd2, 48'd2});
    rows.push_back('{OP_QUERY,  '1, '1, 1'b1, 1'b1, 48'd3, 48'd2});
    rows.push_back('{OP_INSERT, 64'd0, 64'd0, 1'b1, 1'b0, 48'd3, 48'd2});
    rows.push_back('{OP_QUERY,  64'd0, 64'd0, 1'b1, 1'b1, 48'd4, 48'd2});
    rows.push_back('{OP_QUERY,  64'h8000_0000_0000_0001, 64'h5555_aaaa_0f0f_f0f0,
                     1'b0, 1'b0, '0, '0});
    rows.push_back('{OP_INSERT, 64'hAAAA_5555_1234_5678, 64'h7fff_ffff_ffff_ffff,
                     1'b0, 1'b0, '0, '0});
    rows.push_back('{OP_QUERY,  64'hAAAA_5555_1234_5678, 64'h7fff_ffff_ffff_ffff,
                     1'b0, 1'b0, '0, '0});
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].ha, rows[i].hb);
      a = awaited_answers[$];
      if (rows[i].known && a !== answer_t'{rows[i].present, rows[i].qtot, rows[i].mtot}) begin
        $display("%0t: table row %0d expected %h actual prediction %h", $time, i,
                 answer_t'{rows[i].present, rows[i].qtot, rows[i].mtot}, a);
        errors++;
      end
    end

    // Zero probes, single bit, oversized settings, unused register index.
    write_reg(REG_HASH_COUNT, 17'd0);
    send_request(OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
    send_request(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
    write_reg(REG_HASH_COUNT, 17'd31);
    write_reg(REG_BITS_IN_USE, 17'd0);
    send_request(OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
    write_reg(REG_BITS_IN_USE, 17'h1FFFF);
    write_reg(REG_UNUSED, 17'h1FFFF);
    send_request(OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom});

    // Random phases over several settings; the long stall lands in the first.
    write_reg(REG_HASH_COUNT, 17'd2);
    write_reg(REG_BITS_IN_USE, 17'd97);
    hold_off = 1'b1;
    random_phase(150, 16);
    write_reg(REG_HASH_COUNT, 17'd1);
    write_reg(REG_BITS_IN_USE, 17'd1);
    random_phase(40, 8);
    write_reg(REG_HASH_COUNT, 17'd16);
    write_reg(REG_BITS_IN_USE, 17'd65536);
    random_phase(60, 32);
    write_reg(REG_HASH_COUNT, 17'($urandom_range(1, 8)));
    write_reg(REG_BITS_IN_USE, 17'($urandom_range(8, 4096)));
    random_phase(300, 64);

    s_tvalid <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
    idle_cycles(1200);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/bfdh_pkg.sv
rtl/bloom_filter_double_hash_core.sv
sim/bloom_filter_double_hash_core_tb.sv
